// ----- rtl/u8d_pkg.sv -----
package u8d_pkg;

   // One lane per possible sequence length (one to four bytes).
   localparam int NUM_LANES = 4;
   localparam int BYTE_W    = 8;
   localparam int AVAIL_W   = 3;
   localparam int CP_W      = 21;
   localparam int LEN_W     = 3;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [AVAIL_W-1:0] avail_type;
   typedef logic [CP_W-1:0]    cp_type;
   typedef logic [LEN_W-1:0]   len_type;

   localparam len_type   LEN_ONE   = len_type'(1);
   localparam len_type   LEN_TWO   = len_type'(2);
   localparam len_type   LEN_THREE = len_type'(3);
   localparam len_type   LEN_FOUR  = len_type'(4);
   localparam avail_type AVAIL_MAX = avail_type'(4);

   localparam byte_type LEAD2_MIN  = 8'hC2;
   localparam byte_type LEAD2_MAX  = 8'hDF;
   localparam byte_type LEAD3_MIN  = 8'hE0;
   localparam byte_type LEAD3_MAX  = 8'hEF;
   localparam byte_type LEAD_SURR  = 8'hED;
   localparam byte_type LEAD4_MIN  = 8'hF0;
   localparam byte_type LEAD4_MAX  = 8'hF4;
   localparam byte_type CONT_MASK  = 8'hC0;
   localparam byte_type CONT_TAG   = 8'h80;
   localparam byte_type E0_B1_MIN  = 8'hA0;
   localparam byte_type ED_B1_MAX  = 8'h9F;
   localparam byte_type F0_B1_MIN  = 8'h90;
   localparam byte_type F4_B1_MAX  = 8'h8F;

   localparam cp_type CP_MIN3 = 21'h000800;
   localparam cp_type CP_MIN4 = 21'h010000;
   localparam cp_type CP_MAX  = 21'h10FFFF;

   typedef struct packed {
      byte_type  byte0;
      byte_type  byte1;
      byte_type  byte2;
      byte_type  byte3;
      avail_type avail_bytes;
   } req_type;

   typedef struct packed {
      cp_type  code_point;
      len_type consumed;
   } rsp_type;

   typedef struct packed {
      logic   hit;
      cp_type value;
   } lane_res_type;

   function automatic logic is_cont(input byte_type b);
      return (b & CONT_MASK) == CONT_TAG;
   endfunction

endpackage

// ----- rtl/u8d_lane.sv -----
module u8d_lane (
   input  u8d_pkg::req_type      req,
   input  u8d_pkg::len_type      lane_len,
   output u8d_pkg::lane_res_type res
);

   u8d_pkg::avail_type avail_c;
   logic               lead_ok;
   logic               b1_ok;
   logic               cont_ok;
   logic               range_ok;
   u8d_pkg::cp_type    value;

   always_comb begin
      avail_c = (req.avail_bytes > u8d_pkg::AVAIL_MAX) ? u8d_pkg::AVAIL_MAX
                                                         : req.avail_bytes;

      // Tighter second-byte windows that rule out overlongs, surrogates
      // and values above the Unicode range.
      b1_ok = !((req.byte0 == u8d_pkg::LEAD3_MIN) && (req.byte1 < u8d_pkg::E0_B1_MIN)) &&
              !((req.byte0 == u8d_pkg::LEAD_SURR) && (req.byte1 > u8d_pkg::ED_B1_MAX)) &&
              !((req.byte0 == u8d_pkg::LEAD4_MIN) && (req.byte1 < u8d_pkg::F0_B1_MIN)) &&
              !((req.byte0 == u8d_pkg::LEAD4_MAX) && (req.byte1 > u8d_pkg::F4_B1_MAX));

      cont_ok = ((lane_len <= u8d_pkg::LEN_ONE)   || u8d_pkg::is_cont(req.byte1)) &&
                ((lane_len <= u8d_pkg::LEN_TWO)   || u8d_pkg::is_cont(req.byte2)) &&
                ((lane_len <= u8d_pkg::LEN_THREE) || u8d_pkg::is_cont(req.byte3));

      unique case (lane_len)
         u8d_pkg::LEN_ONE: begin
            lead_ok  = ~req.byte0[7];
            value    = {14'd0, req.byte0[6:0]};
            range_ok = 1'b1;
         end
         u8d_pkg::LEN_TWO: begin
            lead_ok  = (req.byte0 >= u8d_pkg::LEAD2_MIN) && (req.byte0 <= u8d_pkg::LEAD2_MAX);
            value    = {10'd0, req.byte0[4:0], req.byte1[5:0]};
            range_ok = 1'b1;
         end
         u8d_pkg::LEN_THREE: begin
            lead_ok  = (req.byte0 >= u8d_pkg::LEAD3_MIN) && (req.byte0 <= u8d_pkg::LEAD3_MAX)
                       && b1_ok;
            value    = {5'd0, req.byte0[3:0], req.byte1[5:0], req.byte2[5:0]};
            range_ok = value >= u8d_pkg::CP_MIN3;
         end
         u8d_pkg::LEN_FOUR: begin
            lead_ok  = (req.byte0 >= u8d_pkg::LEAD4_MIN) && (req.byte0 <= u8d_pkg::LEAD4_MAX)
                       && b1_ok;
            value    = {req.byte0[2:0], req.byte1[5:0], req.byte2[5:0], req.byte3[5:0]};
            range_ok = (value >= u8d_pkg::CP_MIN4) && (value <= u8d_pkg::CP_MAX);
         end
         default: begin
            lead_ok  = 1'b0;
            value    = '0;
            range_ok = 1'b0;
         end
      endcase

      res.hit   = lead_ok && cont_ok && range_ok && (avail_c >= u8d_pkg::avail_type'(lane_len));
      res.value = value;
   end

endmodule

// ----- rtl/u8d_merge.sv -----
module u8d_merge (
   input  u8d_pkg::lane_res_type lanes [u8d_pkg::NUM_LANES],
   output u8d_pkg::rsp_type      rsp
);

   // Lead byte classes are disjoint, so at most one lane hits.
   always_comb begin
      rsp = '0;
      for (int i = 0; i < u8d_pkg::NUM_LANES; i++) begin
         if (lanes[i].hit) begin
            rsp.code_point = rsp.code_point | lanes[i].value;
            rsp.consumed   = rsp.consumed | u8d_pkg::len_type'(i + 1);
         end
      end
   end

endmodule

// ----- rtl/utf8_validating_decoder_top.sv -----
// A result beat appears in the cycle after its request beat is accepted.
// Throughput: one sequence per cycle; the four length lanes and the merge are
// combinational and feed a single output register, so a new beat is taken
// whenever that register is empty or is being drained in the same cycle.
// Reset: synchronous, active high; it empties the output register.
module utf8_validating_decoder_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  u8d_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output u8d_pkg::rsp_type rsp_data
);

   // Each lane tests the request beat against one sequence length: lead byte
   // class, availability, continuation bytes, the special second-byte windows
   // and the scalar range. The merge stage picks the lane that hit, or gives
   // an all-zero result when none did (invalid or truncated).
   u8d_pkg::lane_res_type lane_res [u8d_pkg::NUM_LANES];
   u8d_pkg::rsp_type      merged;

   logic             valid_ff;
   logic             valid_in;
   u8d_pkg::rsp_type rsp_ff;
   u8d_pkg::rsp_type rsp_in;
   logic             req_fire;

   for (genvar g = 0; g < u8d_pkg::NUM_LANES; g++) begin : g_lane
      u8d_lane u_lane (
         .req      (req_data),
         .lane_len (u8d_pkg::len_type'(g + 1)),
         .res      (lane_res[g])
      );
   end

   u8d_merge u_merge (
      .lanes (lane_res),
      .rsp   (merged)
   );

   // The output register accepts a new beat when it is empty or when its
   // current beat leaves in this same cycle.
   assign req_ready = !valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (req_fire) begin
         valid_in = 1'b1;
         rsp_in   = merged;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_one_lane: assert property (@(posedge clock) disable iff (reset)
      $onehot0({lane_res[3].hit, lane_res[2].hit, lane_res[1].hit, lane_res[0].hit}))
      else $error("more than one length lane accepted the same beat");

   a_zero_cp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.consumed == '0)) |-> (rsp_data.code_point == '0))
      else $error("rejected sequence carries a nonzero code point");

   a_accept_shows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_valid && (rsp_data == $past(merged))))
      else $error("accepted beat did not reach the output register");

   a_empty_input: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_data.avail_bytes == '0)) |=> (rsp_data.consumed == '0))
      else $error("beat with no bytes available was not rejected");
`endif

endmodule
